FILE: rtl/core/lgs_pkg.sv
// Shared constants, command codes and control types for the life grid step block.
// No dependencies; lgs_row_unit.sv and life_grid_step.sv in rtl/core import this package.
package lgs_pkg;

  localparam int LGS_SIDE   = 8;   // default board side
  localparam int ROW_BITS   = 8;   // bits given to each row in the result word
  localparam int BOARD_BITS = 64;  // width of the packed result
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 3;
  localparam int IN_BITS    = 8;   // kind, column, row packed, already whole bytes

  localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Command seen by the row unit for the row now being rewritten
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               hit;    // toggle lands in this row and on the board
    logic [COORD_W-1:0] x_col;
  } lgs_ctrl_t;

endpackage

FILE: rtl/core/lgs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/lgs_row_unit.sv
// Next value of one board row from itself and its two neighbour rows.
// Applies toggle, B3/S23 generation, clear or hold; depends on lgs_pkg.
module lgs_row_unit
  import lgs_pkg::*;
#(
  parameter int SIDE = LGS_SIDE
) (
  input  lgs_ctrl_t       ctrl,
  input  logic [SIDE-1:0] prv_row,
  input  logic [SIDE-1:0] cur_row,
  input  logic [SIDE-1:0] nxt_row,
  output logic [SIDE-1:0] new_row
);

  logic [SIDE-1:0] life_row;
  logic [SIDE-1:0] tgl_row;

  always_comb begin
    logic [3:0] n;
    life_row = '0;
    for (int x = 0; x < SIDE; x++) begin
      n = 4'(prv_row[x]) + 4'(nxt_row[x]);
      if (x > 0) begin
        n = n + 4'(prv_row[x-1]) + 4'(cur_row[x-1]) + 4'(nxt_row[x-1]);
      end
      if (x < SIDE - 1) begin
        n = n + 4'(prv_row[x+1]) + 4'(cur_row[x+1]) + 4'(nxt_row[x+1]);
      end
      life_row[x] = (n == 4'd3) || ((n == 4'd2) && cur_row[x]);
    end
  end

  assign tgl_row = ctrl.hit ? (cur_row ^ (SIDE'(1) << ctrl.x_col)) : cur_row;

  always_comb begin
    unique case (ctrl.kind)
      KIND_TOGGLE: new_row = tgl_row;
      KIND_STEP:   new_row = life_row;
      KIND_CLEAR:  new_row = '0;
      default:     new_row = cur_row;  // unused kind: hold the row
    endcase
  end

endmodule

FILE: rtl/core/life_grid_step.sv
// Life grid step: 8x8 (SIDE x SIDE) B3/S23 board held in a row memory.
// Each transaction sweeps the board one row per cycle; after the sweep the
// result is registered and out_tvalid rises, or the board waits in ST_HOLD
// while the output register is full. A new item is accepted only in ST_IDLE.
// Reset clears the per-row valid bits at once, so every cell reads dead; the
// RAM itself is not cleared and no item is held off after reset.
module life_grid_step
  import lgs_pkg::*;
#(
  parameter int SIDE = LGS_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_BITS-1:0]    in_tdata,   // [1:0] kind, [4:2] x_column, [7:5] y_row
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BOARD_BITS-1:0] out_tdata   // [63:0] board_bits
);

  localparam int AW = $clog2(SIDE);
  localparam int CW = $clog2(SIDE + 2);
  localparam logic [CW-1:0] C_LAST = CW'(SIDE + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  state_t                  st_r, st_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [SIDE-1:0]         row_vld_r, row_vld_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [COORD_W-1:0]      x_r, x_nxt;
  logic [COORD_W-1:0]      y_r, y_nxt;
  logic [SIDE-1:0]         prv_r, prv_nxt;
  logic [SIDE-1:0]         cur_r, cur_nxt;
  logic [BOARD_BITS-1:0]   asm_r, asm_nxt;
  logic [BOARD_BITS-1:0]   out_r, out_nxt;

  logic                    accept;
  logic                    rd_issue;
  logic [AW-1:0]           rd_addr;
  logic [SIDE-1:0]         ram_rdata;
  logic [SIDE-1:0]         nxt_row;
  logic                    wr_en;
  logic [CW-1:0]           wr_cnt;
  logic [AW-1:0]           wr_addr;
  logic [SIDE-1:0]         new_row;
  lgs_ctrl_t               ctrl;
  logic                    out_free;

  assign in_tready  = (st_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;
  assign out_free   = !out_vld_r || out_tready;

  assign rd_issue = (st_r == ST_SWEEP) && (cnt_r < CW'(SIDE));
  assign rd_addr  = cnt_r[AW-1:0];
  // Rows above the top or below the bottom arrive as dead
  assign nxt_row  = rd_vld_r ? ram_rdata : '0;
  assign wr_en    = (st_r == ST_SWEEP) && (cnt_r >= CW'(2));
  assign wr_cnt   = cnt_r - CW'(2);
  assign wr_addr  = wr_cnt[AW-1:0];

  assign ctrl.kind  = kind_r;
  assign ctrl.x_col = x_r;
  assign ctrl.hit   = (kind_r == KIND_TOGGLE) && (int'(x_r) < SIDE) &&
                      (int'(y_r) < SIDE) && (y_r == COORD_W'(wr_addr));

  lgs_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (new_row),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  lgs_row_unit #(
    .SIDE (SIDE)
  ) u_row (
    .ctrl    (ctrl),
    .prv_row (prv_r),
    .cur_row (cur_r),
    .nxt_row (nxt_row),
    .new_row (new_row)
  );

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    row_vld_nxt = row_vld_r;
    rd_vld_nxt  = rd_issue ? row_vld_r[rd_addr] : 1'b0;
    out_vld_nxt = out_vld_r;
    kind_nxt    = kind_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    prv_nxt     = prv_r;
    cur_nxt     = cur_r;
    asm_nxt     = asm_r;
    out_nxt     = out_r;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    if (wr_en) begin
      row_vld_nxt[wr_addr] = 1'b1;
      for (int r = 0; r < SIDE; r++) begin
        if (wr_addr == AW'(r)) begin
          asm_nxt[r*ROW_BITS +: ROW_BITS] = ROW_BITS'(new_row);
        end
      end
    end

    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_tdata[1:0];
          x_nxt    = in_tdata[4:2];
          y_nxt    = in_tdata[7:5];
          prv_nxt  = '0;
          cur_nxt  = '0;
          asm_nxt  = '0;
          cnt_nxt  = '0;
          st_nxt   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // Slide the three-row window down by one
        prv_nxt = cur_r;
        cur_nxt = nxt_row;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == C_LAST) begin
          if (out_free) begin
            out_nxt     = asm_nxt;
            out_vld_nxt = 1'b1;
            st_nxt      = ST_IDLE;
          end else begin
            st_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // Hold the finished board until the output register frees up
        if (out_free) begin
          out_nxt     = asm_r;
          out_vld_nxt = 1'b1;
          st_nxt      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      row_vld_r <= row_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    prv_r  <= prv_nxt;
    cur_r  <= cur_nxt;
    asm_r  <= asm_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking life_grid_step bench: drives toggle, step, clear and unused commands
// and checks every returned board. Depends on lgs_pkg and rtl/core/life_grid_step.sv.
module testbench;
  import lgs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS  = 1350;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 3 * (LGS_SIDE + 3);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_BITS-1:0]    in_tdata = '0;    // [1:0] kind, [4:2] x_column, [7:5] y_row
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BOARD_BITS-1:0] out_tdata;        // [63:0] board_bits

  bit long_hold_req = 1'b0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  // Board predictor and store of boards still owed by the block
  class life_scoreboard;
    logic [ROW_BITS-1:0]   cells [8];
    logic [BOARD_BITS-1:0] owed_boards [$];
    int fails = 0;

    function void wipe();
      foreach (cells[r]) cells[r] = '0;
    endfunction

    function logic alive(int x, int y);
      if (x < 0 || y < 0 || x >= LGS_SIDE || y >= LGS_SIDE) return 1'b0;
      return cells[y][x];
    endfunction

    function void next_generation();
      logic [ROW_BITS-1:0] nxt [8];
      int n;
      for (int y = 0; y < 8; y++) begin
        nxt[y] = '0;
        for (int x = 0; x < LGS_SIDE && y < LGS_SIDE; x++) begin
          n = 0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0) n += int'(alive(x + dx, y + dy));
          if (n == 3 || (n == 2 && alive(x, y))) nxt[y][x] = 1'b1;
        end
      end
      cells = nxt;
    endfunction

    function void note_command(logic [IN_BITS-1:0] cmd);
      logic [KIND_W-1:0]     kind;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      logic [BOARD_BITS-1:0] word;
      kind = cmd[1:0];
      col  = cmd[4:2];
      row  = cmd[7:5];
      case (kind)
        KIND_TOGGLE: begin
          if (col < LGS_SIDE && row < LGS_SIDE) cells[row][col] = ~cells[row][col];
        end
        KIND_STEP:  next_generation();
        KIND_CLEAR: wipe();
        default: ;
      endcase
      for (int r = 0; r < 8; r++) word[r*ROW_BITS +: ROW_BITS] = cells[r];
      owed_boards.push_back(word);
    endfunction

    function void check_board(logic [BOARD_BITS-1:0] got);
      logic [BOARD_BITS-1:0] want;
      if (owed_boards.size() == 0) begin
        fails++;
        if (fails <= 50) $display("%0t: board %h returned with no command pending", $time, got);
      end else begin
        want = owed_boards.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 50)
            $display("%0t: board mismatch: expected %h, actual %h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return owed_boards.size();
    endfunction
  endclass

  life_scoreboard board_sb;

  life_grid_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board_sb.check_board(out_tdata);
      if (in_tvalid && in_tready) board_sb.note_command(in_tdata);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall pattern changes after each random span; honour long holds
  initial begin
    int mode;
    int span;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= (c % 4 != 0);
          2: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (c % 5 == 0);
        endcase
      end
    end
  end

  // Offer one command; open a new burst after a random gap when the last one ends
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input int col, input int row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 20);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {COORD_W'(row), COORD_W'(col), kind};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Hold the sender until the block has returned every board
  task automatic drain_boards();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board_sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int next_hold;
    int next_drain;
    int x0;
    int y0;
    bit dense;
    board_sb = new();
    board_sb.wipe();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Corners, lone cells dying, blinker, ignored coordinates, unused kind
    send_cmd(KIND_TOGGLE, 0, 0);
    send_cmd(KIND_TOGGLE, 7, 0);
    send_cmd(KIND_TOGGLE, 0, 7);
    send_cmd(KIND_TOGGLE, 7, 7);
    send_cmd(KIND_STEP, 0, 0);
    send_cmd(KIND_TOGGLE, 3, 3);
    send_cmd(KIND_TOGGLE, 4, 3);
    send_cmd(KIND_TOGGLE, 5, 3);
    send_cmd(KIND_STEP, 7, 7);
    send_cmd(KIND_STEP, 2, 5);
    send_cmd(KIND_UNUSED, 7, 7);
    send_cmd(KIND_CLEAR, 5, 6);
    // Birth in a corner forming a still block
    send_cmd(KIND_TOGGLE, 0, 0);
    send_cmd(KIND_TOGGLE, 1, 0);
    send_cmd(KIND_TOGGLE, 0, 1);
    send_cmd(KIND_STEP, 0, 0);
    send_cmd(KIND_STEP, 7, 0);
    send_cmd(KIND_CLEAR, 7, 7);
    // Glider heading for the border
    send_cmd(KIND_TOGGLE, 1, 0);
    send_cmd(KIND_TOGGLE, 2, 1);
    send_cmd(KIND_TOGGLE, 0, 2);
    send_cmd(KIND_TOGGLE, 1, 2);
    send_cmd(KIND_TOGGLE, 2, 2);
    send_cmd(KIND_STEP, 0, 7);
    send_cmd(KIND_STEP, 3, 4);
    drain_boards();

    next_hold  = 400;
    next_drain = 700;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_hold) begin
        long_hold_req = 1'b1;
        next_hold += 500;
      end
      if (items_sent >= next_drain) begin
        drain_boards();
        next_drain += 350;
      end
      if ($urandom_range(0, 9) < 7) begin
        // Seed a pattern in a small window (or anywhere), then let it evolve
        if ($urandom_range(0, 2) != 0) send_cmd(KIND_CLEAR, $urandom_range(0, 7),
                                                $urandom_range(0, 7));
        dense = ($urandom_range(0, 3) == 0);
        x0 = $urandom_range(0, LGS_SIDE - 4);
        y0 = $urandom_range(0, LGS_SIDE - 4);
        repeat ($urandom_range(3, 12)) begin
          if (dense) send_cmd(KIND_TOGGLE, $urandom_range(0, 7), $urandom_range(0, 7));
          else send_cmd(KIND_TOGGLE, x0 + $urandom_range(0, 3), y0 + $urandom_range(0, 3));
        end
        repeat ($urandom_range(1, 8))
          send_cmd(KIND_STEP, $urandom_range(0, 7), $urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, 6))
          send_cmd(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 7));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board_sb.pending() != 0)
      $display("%0t: %0d boards never returned", $time, board_sb.pending());
    if (board_sb.fails == 0 && board_sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
